// File: rtl/swbm_pkg.sv
`timescale 1ns / 1ps
package swbm_pkg;

	localparam int WINDOW     = 21;
	localparam int SECTIONS   = 32;
	localparam int SAMPLE_W   = 32;
	localparam int CNT_W      = $clog2(WINDOW + 1);
	localparam int BYTE_W     = 8;
	localparam int HEADER_LEN = 4;
	localparam int WORD_BYTES = SAMPLE_W / BYTE_W;
	localparam int FRAME_LEN  = HEADER_LEN + WORD_BYTES;
	localparam int IDX_W      = $clog2(FRAME_LEN);
	localparam int BSEL_W     = $clog2(WORD_BYTES);

	localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'hFF;
	localparam logic [IDX_W-1:0]  IDX_FIRST_DATA = IDX_W'(HEADER_LEN);
	localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(FRAME_LEN - 1);

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [CNT_W-1:0]    count_t;

endpackage

// File: rtl/swbm_cell.sv
`timescale 1ns / 1ps
module swbm_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift,
	input  swbm_pkg::sample_t d,
	output swbm_pkg::sample_t q
);
	import swbm_pkg::*;

	sample_t word_q;

	// window slots count as zero samples until pushed out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else if (shift) begin
			word_q <= d;
		end
	end

	assign q = word_q;

endmodule

// File: rtl/swbm_tally.sv
`timescale 1ns / 1ps
module swbm_tally (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift,
	input  swbm_pkg::sample_t newest,
	input  swbm_pkg::sample_t oldest,
	output swbm_pkg::sample_t filtered
);
	import swbm_pkg::*;

	count_t cnt_q [SECTIONS];

	genvar n;
	generate
		for (n = 0; n < SAMPLE_W; n++) begin : g_lane
			if (n < SECTIONS) begin : g_cnt
				// running count of ones in this bit across the window
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						cnt_q[n] <= '0;
					end else if (shift) begin
						cnt_q[n] <= cnt_q[n] + CNT_W'(newest[n]) - CNT_W'(oldest[n]);
					end
				end
				// ones > zeros, a tie gives 0
				assign filtered[n] = {cnt_q[n], 1'b0} > (CNT_W + 1)'(WINDOW);
			end else begin : g_off
				assign filtered[n] = 1'b0;
			end
		end
	endgenerate

endmodule

// File: rtl/swbm_framer.sv
`timescale 1ns / 1ps
module swbm_framer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  swbm_pkg::sample_t         word,
	input  logic                      out_stall,
	output logic                      free,
	output logic                      out_valid,
	output logic [swbm_pkg::BYTE_W-1:0] frame_byte,
	output logic                      frame_last
);
	import swbm_pkg::*;

	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	sample_t          word_q;
	logic             fire;
	logic             at_last;
	logic [IDX_W-1:0] widx;

	assign fire    = busy_q && !out_stall;
	assign at_last = idx_q == IDX_LAST;
	assign free    = !busy_q || (fire && at_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (fire) begin
			if (at_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= word;
		end
	end

	assign widx       = idx_q - IDX_FIRST_DATA;
	assign out_valid  = busy_q;
	assign frame_last = at_last;
	assign frame_byte = (idx_q < IDX_FIRST_DATA) ? HEADER_BYTE
		: word_q[BYTE_W * widx[BSEL_W-1:0] +: BYTE_W];

endmodule

// File: rtl/sliding_window_bit_majority_top.sv
`timescale 1ns / 1ps
// channel | handshake          | payload
// input   | in_valid, in_stall   | occupancy_sample
// output  | out_valid, out_stall | frame_byte, frame_last
//
// each item yields eight output bytes, one per cycle while out_stall is low; the
// byte serializer sets the sustained rate.
// first byte is offered once the item is registered in pend_q and then loaded into busy_q; the next item is
// taken while the current frame is still being sent (one accepted item waits in pend_q).
// reset clears the window and the per-section counts to zero.
// out_stall holds the current byte; in_stall rises only while an item waits for the serializer.
module sliding_window_bit_majority_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  swbm_pkg::sample_t           occupancy_sample,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [swbm_pkg::BYTE_W-1:0] frame_byte,
	output logic                        frame_last
);
	import swbm_pkg::*;

	sample_t win [WINDOW];
	sample_t filtered;
	logic    accept;
	logic    pend_q;
	logic    free;
	logic    load;

	assign load     = pend_q && free;
	assign in_stall = pend_q && !free;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (accept) begin
			pend_q <= 1'b1;
		end else if (load) begin
			pend_q <= 1'b0;
		end
	end

	// newest sample enters at the top slot, slot 0 holds the oldest
	genvar k;
	generate
		for (k = 0; k < WINDOW; k++) begin : g_win
			if (k == WINDOW - 1) begin : g_head
				swbm_cell u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.shift  (accept),
					.d      (occupancy_sample),
					.q      (win[k])
				);
			end else begin : g_body
				swbm_cell u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.shift  (accept),
					.d      (win[k+1]),
					.q      (win[k])
				);
			end
		end
	endgenerate

	swbm_tally u_tally (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift    (accept),
		.newest   (occupancy_sample),
		.oldest   (win[0]),
		.filtered (filtered)
	);

	swbm_framer u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.word       (filtered),
		.out_stall  (out_stall),
		.free       (free),
		.out_valid  (out_valid),
		.frame_byte (frame_byte),
		.frame_last (frame_last)
	);

endmodule

// File: tb/swbm_frame_checker.sv
`timescale 1ns / 1ps
module swbm_frame_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  swbm_pkg::sample_t           occupancy_sample,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [swbm_pkg::BYTE_W-1:0] frame_byte,
	input  logic                        frame_last,
	output int                          fail_count,
	output int                          pending_bytes,
	output int                          checked_bytes
);
	import swbm_pkg::*;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} frame_beat_t;

	sample_t     occupancy_history [WINDOW];
	frame_beat_t expected_beats [$];
	int          mismatches;
	int          beats_seen;

	function automatic sample_t voted_word();
		sample_t word;
		int      ones;
		word = '0;
		for (int n = 0; n < SAMPLE_W && n < SECTIONS; n++) begin
			ones = 0;
			for (int k = 0; k < WINDOW; k++)
				ones += occupancy_history[k][n];
			// strict majority, a tie stays 0
			if (ones > WINDOW - ones)
				word[n] = 1'b1;
		end
		return word;
	endfunction

	task automatic predict_frame(input sample_t sample);
		sample_t     filtered;
		frame_beat_t beat;
		for (int k = 0; k < WINDOW - 1; k++)
			occupancy_history[k] = occupancy_history[k + 1];
		occupancy_history[WINDOW - 1] = sample;
		filtered = voted_word();
		for (int k = 0; k < FRAME_LEN; k++) begin
			if (k < HEADER_LEN)
				beat.data = HEADER_BYTE;
			else
				beat.data = filtered[(k - HEADER_LEN) * BYTE_W +: BYTE_W];
			beat.last = (k == FRAME_LEN - 1);
			expected_beats.push_back(beat);
		end
	endtask

	task automatic compare_beat();
		frame_beat_t want;
		beats_seen++;
		if (expected_beats.size() == 0) begin
			if (mismatches < 10)
				$display("%0t: unexpected frame byte %h last %b", $realtime, frame_byte,
					frame_last);
			mismatches++;
		end else begin
			want = expected_beats.pop_front();
			if (frame_byte !== want.data || frame_last !== want.last) begin
				if (mismatches < 10)
					$display("%0t: frame byte %h last %b, expected byte %h last %b",
						$realtime, frame_byte, frame_last, want.data, want.last);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WINDOW; k++)
				occupancy_history[k] = '0;
			expected_beats.delete();
			mismatches = 0;
			beats_seen = 0;
			fail_count <= 0;
			pending_bytes <= 0;
			checked_bytes <= 0;
		end else begin
			if (in_valid && !in_stall)
				predict_frame(occupancy_sample);
			if (out_valid && !out_stall)
				compare_beat();
			fail_count <= mismatches;
			pending_bytes <= expected_beats.size();
			checked_bytes <= beats_seen;
		end
	end

endmodule

// File: tb/sliding_window_bit_majority_top_tb.sv
`timescale 1ns / 1ps
module sliding_window_bit_majority_top_tb;
	import swbm_pkg::*;

	localparam int RANDOM_SAMPLES = 257;
	localparam int QUIET_LIMIT    = 2000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	sample_t           occupancy_sample = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [BYTE_W-1:0] frame_byte;
	logic              frame_last;

	int fail_count;
	int pending_bytes;
	int checked_bytes;
	int samples_sent = 0;
	int quiet_cycles = 0;
	bit idle_on = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	sliding_window_bit_majority_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.occupancy_sample (occupancy_sample),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.frame_byte       (frame_byte),
		.frame_last       (frame_last)
	);

	swbm_frame_checker frame_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.occupancy_sample (occupancy_sample),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.frame_byte       (frame_byte),
		.frame_last       (frame_last),
		.fail_count       (fail_count),
		.pending_bytes    (pending_bytes),
		.checked_bytes    (checked_bytes)
	);

	function automatic int draw_wait();
		return idle_on ? int'($urandom_range(0, 13)) : 0;
	endfunction

	task automatic offer_sample(input sample_t sample);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		occupancy_sample <= sample;
		do @(posedge clk); while (in_stall);
		samples_sent++;
	endtask

	// caller lowers in_valid first; pending_bytes is not checked on entry, only after waiting on the clock
	task automatic wait_frames_done();
		do @(posedge clk); while (pending_bytes != 0);
	endtask

	initial begin : receiver
		int hold;
		forever begin
			hold = draw_wait();
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("no handshake for %0d cycles", QUIET_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		sample_t base;
		int      pick;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// window starts all zero; majority turns on with the eleventh all-ones item
		offer_sample('0);
		repeat (11) offer_sample('1);
		offer_sample(32'hAAAA_AAAA);
		offer_sample(32'h5555_5555);
		offer_sample(32'h0000_0001);
		offer_sample(32'h8000_0000);
		offer_sample(32'h0F0F_00FF);
		repeat (6) offer_sample('0);

		base = $urandom();
		for (int k = 0; k < RANDOM_SAMPLES; k++) begin
			idle_on = ((k / 50) % 3) != 1;
			if (k == 120) begin
				in_valid <= 1'b0;
				wait_frames_done();
			end
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				// steady occupancy with sparse flicker, so majorities actually flip
				if ($urandom_range(0, 7) == 0)
					base = $urandom();
				offer_sample(base ^ ($urandom() & $urandom() & $urandom()));
			end else if (pick < 9) begin
				offer_sample($urandom());
			end else begin
				offer_sample({SAMPLE_W{1'($urandom_range(0, 1))}});
			end
		end

		in_valid <= 1'b0;
		wait_frames_done();
		repeat (16) @(posedge clk);

		$display("%0d occupancy samples (window fill and drain, steady and noisy tracks)",
			samples_sent);
		$display("%0d frame bytes checked under random gaps, stalls and a full drain",
			checked_bytes);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
